/* hw/rtl/ase_pkg.sv */
// Shared types and constants for the array set engine.
package ase_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int CMD_W    = 2;
   localparam int RSP_W    = ((2 + COUNT_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

endpackage

/* hw/rtl/array_set_engine.sv */
// Array set engine: unsorted value store with lookup, add, delete and clear.
//
// Input items arrive on the req_ channel: req_tuser holds the command
// (lookup, add, delete, clear) and req_tdata the 32-bit value. Each item
// yields exactly one result item on the rsp_ channel with found, accepted
// and the entry count after the operation.
// One item is worked on at a time; req_tready is high only while the
// sequencer is idle. Add and clear pass from EXEC straight to DONE.
// Lookup and delete walk the stored entries through a single memory read
// port, one entry per cycle (lookup stops at the first match), so a scan
// is longest with a full store.
// Delete compacts the surviving entries in place through the write port
// while the scan goes on.
// The result sits in an output register; if the receiver stalls, the next
// item can still be accepted and worked on, and its result waits until the
// register is freed.
// Reset (synchronous) empties the set and drops any pending result; the
// memory itself is not cleared, only entries below the count are ever read.
module array_set_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ase_pkg::VALUE_W-1:0] req_tdata,   // value
   input  logic [ase_pkg::CMD_W-1:0]   req_tuser,   // cmd
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ase_pkg::RSP_W-1:0]   rsp_tdata    // found, accepted, count, zero pad
);
   import ase_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic [COUNT_W-1:0]   used_ff, used_in;
   logic [COUNT_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic                 pend_ff, pend_in;
   logic                 found_ff, found_in;
   logic                 accepted_ff, accepted_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]     rsp_tdata_ff, rsp_tdata_in;

   logic [VALUE_W-1:0]   mem [CAPACITY];
   logic [VALUE_W-1:0]   mem_q_ff;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [VALUE_W-1:0]   mem_wdata;
   logic [ADDR_W-1:0]    mem_raddr;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign mem_raddr  = rd_ptr_ff[ADDR_W-1:0];

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      used_in       = used_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      pend_in       = 1'b0;
      found_in      = found_ff;
      accepted_in   = accepted_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      mem_we        = 1'b0;
      mem_waddr     = wr_ptr_ff[ADDR_W-1:0];
      mem_wdata     = mem_q_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in      = cmd_type'(req_tuser);
               value_in    = req_tdata;
               found_in    = 1'b0;
               accepted_in = 1'b0;
               rd_ptr_in   = '0;
               wr_ptr_in   = '0;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cmd_ff)
               CMD_ADD: begin
                  if (used_ff < COUNT_W'(CAPACITY)) begin
                     mem_we      = 1'b1;
                     mem_waddr   = used_ff[ADDR_W-1:0];
                     mem_wdata   = value_ff;
                     used_in     = used_ff + COUNT_W'(1);
                     accepted_in = 1'b1;
                  end
                  state_in = ST_DONE;
               end
               CMD_CLEAR: begin
                  used_in  = '0;
                  state_in = ST_DONE;
               end
               default: begin
                  state_in = ST_SCAN;
               end
            endcase
         end
         ST_SCAN: begin
            // issue the next read while the previous entry is compared
            if (rd_ptr_ff < used_ff) begin
               rd_ptr_in = rd_ptr_ff + COUNT_W'(1);
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               if (cmd_ff == CMD_LOOKUP) begin
                  if (mem_q_ff == value_ff) begin
                     found_in = 1'b1;
                     pend_in  = 1'b0;
                     state_in = ST_DONE;
                  end
               end else if (mem_q_ff != value_ff) begin
                  // keep the entry: compact it down to the write pointer
                  mem_we    = 1'b1;
                  wr_ptr_in = wr_ptr_ff + COUNT_W'(1);
               end
            end else if (rd_ptr_ff >= used_ff) begin
               if (cmd_ff == CMD_DELETE) begin
                  used_in = wr_ptr_ff;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = RSP_W'({used_ff, accepted_ff, found_ff});
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      cmd_ff       <= cmd_in;
      value_ff     <= value_in;
      rd_ptr_ff    <= rd_ptr_in;
      wr_ptr_ff    <= wr_ptr_in;
      found_ff     <= found_in;
      accepted_ff  <= accepted_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= mem[mem_raddr];
   end

endmodule

/* tb/sv/set_tracker_pkg.sv */
// Expected-result tracker for the array set engine testbench.
package set_tracker_pkg;

   import ase_pkg::*;

   // Field layout matches the low bits of rsp_tdata: found, accepted, count.
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               accepted;
      logic               found;
   } set_reply;

   class set_tracker;
      logic [VALUE_W-1:0] stored_vals [CAPACITY];
      int                 stored_count;
      set_reply           expected_replies [$];
      int                 mismatches;

      function new();
         stored_count = 0;
         mismatches   = 0;
      endfunction

      // Apply one accepted command to the tracked set and queue its reply.
      function void apply_command(cmd_type op, logic [VALUE_W-1:0] value);
         set_reply r;
         int       keep;
         r    = '0;
         keep = 0;
         case (op)
            CMD_LOOKUP: begin
               for (int i = 0; i < stored_count; i++)
                  if (stored_vals[i] == value) r.found = 1'b1;
            end
            CMD_ADD: begin
               if (stored_count < CAPACITY) begin
                  stored_vals[stored_count] = value;
                  stored_count++;
                  r.accepted = 1'b1;
               end
            end
            CMD_DELETE: begin
               // compact survivors in order, dropping every copy
               for (int i = 0; i < stored_count; i++) begin
                  if (stored_vals[i] != value) begin
                     stored_vals[keep] = stored_vals[i];
                     keep++;
                  end
               end
               stored_count = keep;
            end
            default: stored_count = 0;
         endcase
         r.count = COUNT_W'(stored_count);
         expected_replies.push_back(r);
      endfunction

      task report(string what, int want, int got);
         if (mismatches < 100)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
         mismatches++;
      endtask

      task check_response(logic [RSP_W-1:0] data);
         set_reply got;
         set_reply want;
         got = set_reply'(data[COUNT_W+1:0]);
         if (expected_replies.size() == 0) begin
            report("result with nothing pending, count", -1, got.count);
         end else begin
            want = expected_replies.pop_front();
            if (got.found != want.found) report("found", want.found, got.found);
            if (got.accepted != want.accepted)
               report("accepted", want.accepted, got.accepted);
            if (got.count != want.count) report("count", want.count, got.count);
         end
      endtask
   endclass

endpackage

/* tb/sv/tb.sv */
// Top-level testbench for the array set engine.
module tb;

   import ase_pkg::*;
   import set_tracker_pkg::*;

   localparam logic [VALUE_W-1:0] DUP_VALUE    = 32'h1234_5678;
   localparam logic [VALUE_W-1:0] ABSENT_VALUE = 32'h8000_0001;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [VALUE_W-1:0] req_tdata  = '0;   // value
   logic [CMD_W-1:0]   req_tuser  = '0;   // cmd
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;         // found, accepted, count, zero pad

   set_tracker         tracker;
   logic [VALUE_W-1:0] value_pool [8];
   int                 gap_odds   = 0;
   int                 stall_odds = 0;

   array_set_engine DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata);
   end

   // Receiver: stall in random bursts while stall_odds is nonzero.
   initial begin
      forever begin
         @(posedge clock);
         if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic int pick_odds();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 2;
         2:       return 4;
         default: return 8;
      endcase
   endfunction

   // Mix of pool values, values already stored, extremes and fully random ones.
   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      if ($urandom_range(0, 15) == 0) value_pool[$urandom_range(0, 7)] = $urandom();
      case ($urandom_range(0, 9))
         0, 1, 2: v = value_pool[$urandom_range(0, 7)];
         3, 4: begin
            if (tracker.stored_count > 0)
               v = tracker.stored_vals[$urandom_range(0, tracker.stored_count - 1)];
            else
               v = $urandom();
         end
         5: begin
            case ($urandom_range(0, 3))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7FFF_FFFF;
               2:       v = 32'h0000_0000;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
         default: v = $urandom();
      endcase
      return v;
   endfunction

   task automatic send_item(input cmd_type op, input logic [VALUE_W-1:0] value);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.apply_command(op, value);
   endtask

   task automatic drain_replies();
      req_tvalid <= 1'b0;
      while (tracker.expected_replies.size() != 0) @(posedge clock);
   endtask

   task automatic run_random(input int n_items, input bit allow_idle);
      cmd_type op;
      int      roll;
      for (int n = 0; n < n_items; n++) begin
         if (n % 40 == 0) begin
            gap_odds   = allow_idle ? pick_odds() : 0;
            stall_odds = allow_idle ? pick_odds() : 0;
         end
         roll = $urandom_range(0, 99);
         if (roll < 40)      op = CMD_ADD;
         else if (roll < 70) op = CMD_LOOKUP;
         else if (roll < 93) op = CMD_DELETE;
         else                op = CMD_CLEAR;
         // keep the store small so scans stay short
         if (tracker.stored_count > 48 && $urandom_range(0, 3) == 0) op = CMD_CLEAR;
         send_item(op, pick_value());
      end
   endtask

   initial begin
      tracker = new();
      foreach (value_pool[i]) value_pool[i] = $urandom();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store, extremes, duplicates, deletes at first, middle and last position
      send_item(CMD_LOOKUP, 32'h0000_0000);
      send_item(CMD_DELETE, 32'h0000_0005);
      send_item(CMD_ADD,    32'h8000_0000);
      send_item(CMD_ADD,    32'h7FFF_FFFF);
      send_item(CMD_ADD,    32'h0000_0000);
      send_item(CMD_ADD,    32'hFFFF_FFFF);
      send_item(CMD_ADD,    32'h7FFF_FFFF);
      send_item(CMD_LOOKUP, 32'h8000_0000);
      send_item(CMD_LOOKUP, 32'hFFFF_FFFF);
      send_item(CMD_LOOKUP, 32'h0000_0001);
      send_item(CMD_LOOKUP, 32'hFFFF_FFFE);
      send_item(CMD_DELETE, 32'h7FFF_FFFF);
      send_item(CMD_LOOKUP, 32'h7FFF_FFFF);
      send_item(CMD_LOOKUP, 32'h0000_0000);
      send_item(CMD_DELETE, 32'h0000_0001);
      send_item(CMD_DELETE, 32'h8000_0000);
      send_item(CMD_DELETE, 32'hFFFF_FFFF);
      send_item(CMD_CLEAR,  32'hFFFF_FFFF);
      send_item(CMD_LOOKUP, 32'h0000_0000);
      send_item(CMD_ADD,    32'h5555_5555);
      send_item(CMD_ADD,    32'hAAAA_AAAA);
      send_item(CMD_CLEAR,  32'h0000_0000);
      send_item(CMD_CLEAR,  32'h0000_0000);
      drain_replies();

      run_random(440, 1'b1);

      // spread copies of one value through the store, then remove every copy
      gap_odds   = 4;
      stall_odds = 4;
      send_item(CMD_CLEAR, pick_value());
      for (int i = 0; i < 24; i++)
         send_item(CMD_ADD, (i % 5 == 0) ? DUP_VALUE : {1'b0, 31'($urandom())});
      send_item(CMD_LOOKUP, tracker.stored_vals[23]);
      send_item(CMD_LOOKUP, ABSENT_VALUE);
      send_item(CMD_DELETE, ABSENT_VALUE);
      drain_replies();
      send_item(CMD_DELETE, DUP_VALUE);
      send_item(CMD_LOOKUP, DUP_VALUE);
      send_item(CMD_ADD, DUP_VALUE);
      send_item(CMD_LOOKUP, DUP_VALUE);
      send_item(CMD_CLEAR, pick_value());

      run_random(80, 1'b0);

      drain_replies();
      repeat (CAPACITY + 8) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
